@@ hdl/ctg_pkg.sv @@
package ctg_pkg;

    // default sizing
    localparam int DEF_MAX_SIDES   = 64;
    localparam int DEF_ANGLE_STEPS = 4096;

    // field and register widths
    localparam int SIDE_COUNT_W = 7;
    localparam int RADIUS_W     = 32;
    localparam int COORD_W      = 32;
    localparam int CFG_DATA_W   = 32;
    localparam int CFG_INDEX_W  = 2;
    localparam int TRIG_W       = 16;
    localparam int TRIG_MAG_W   = 15;

    // register reset values
    localparam logic [SIDE_COUNT_W-1:0] SIDE_COUNT_RESET = 7'd16;
    localparam logic [RADIUS_W-1:0]     RADIUS_RESET     = 32'd65536;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SIDE_COUNT = 2'd0,
        CFG_RADIUS     = 2'd1,
        CFG_MODE       = 2'd2
    } t_cfg_index;

    // output mode
    typedef enum logic {
        MODE_FAN  = 1'b0,
        MODE_LINE = 1'b1
    } t_mode;

    // input transaction payload
    typedef struct packed {
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
    } t_in_item;

    // output transaction payload
    typedef struct packed {
        logic signed [COORD_W-1:0] hub_x;
        logic signed [COORD_W-1:0] hub_y;
        logic signed [COORD_W-1:0] lead_x;
        logic signed [COORD_W-1:0] lead_y;
        logic signed [COORD_W-1:0] trail_x;
        logic signed [COORD_W-1:0] trail_y;
        logic                      last;
    } t_out_item;

    // control that travels with each rim vertex down the pipeline
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } t_ctl;

    // one rim vertex
    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } t_vertex;

    // divider status
    typedef struct packed {
        logic busy;
    } t_div_status;

endpackage

@@ hdl/ctg_div.sv @@
module ctg_div
    import ctg_pkg::*;
#(
    parameter int MAX_SIDES   = DEF_MAX_SIDES,
    parameter int ANGLE_STEPS = DEF_ANGLE_STEPS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic [$clog2(MAX_SIDES+1)-1:0]       i_divisor,
    output t_div_status                          o_status,
    output logic [$clog2(ANGLE_STEPS+1)-1:0]     o_quot,
    output logic [$clog2(MAX_SIDES+1)-1:0]       o_rem
);

    localparam int SIDE_W = $clog2(MAX_SIDES + 1);
    localparam int ANG_W  = $clog2(ANGLE_STEPS + 1);
    localparam int CNT_W  = $clog2(ANG_W + 1);

    logic              r_busy;
    logic [CNT_W-1:0]  r_cnt;
    logic [ANG_W-1:0]  r_quot;
    logic [SIDE_W-1:0] r_rem;
    logic [SIDE_W-1:0] r_div;

    logic [SIDE_W:0]   trial;
    logic              ge;
    logic [SIDE_W-1:0] n_rem;

    // one restoring step: bring down the next dividend bit
    always_comb begin
        trial = {r_rem, r_quot[ANG_W-1]};
        ge    = (trial >= {1'b0, r_div});
        n_rem = ge ? SIDE_W'(trial - {1'b0, r_div}) : SIDE_W'(trial);
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(ANG_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // dividend shifts out while quotient bits shift in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= ANG_W'(ANGLE_STEPS);
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_quot <= {r_quot[ANG_W-2:0], ge};
            r_rem  <= n_rem;
        end
    end

    assign o_status.busy = r_busy;
    assign o_quot        = r_quot;
    assign o_rem         = r_rem;

endmodule

@@ hdl/ctg_seq.sv @@
module ctg_seq
    import ctg_pkg::*;
#(
    parameter int MAX_SIDES   = DEF_MAX_SIDES,
    parameter int ANGLE_STEPS = DEF_ANGLE_STEPS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic                                 i_start,
    input  t_in_item                             i_center,
    input  logic [$clog2(MAX_SIDES+1)-1:0]       i_sides,
    input  logic [$clog2(ANGLE_STEPS+1)-1:0]     i_quot,
    input  logic [$clog2(MAX_SIDES+1)-1:0]       i_rem,
    output logic                                 o_busy,
    output t_ctl                                 o_ctl,
    output logic [$clog2(ANGLE_STEPS)-1:0]       o_k,
    output t_in_item                             o_center
);

    localparam int SIDE_W = $clog2(MAX_SIDES + 1);
    localparam int ANG_W  = $clog2(ANGLE_STEPS + 1);
    localparam int K_W    = $clog2(ANGLE_STEPS);

    logic              r_busy;
    logic [SIDE_W-1:0] r_j;
    logic [ANG_W-1:0]  r_ang;
    logic [SIDE_W-1:0] r_rem;
    t_in_item          r_center;

    logic [SIDE_W:0]   rem_sum;
    logic              carry;
    logic [SIDE_W-1:0] n_rem;
    logic [ANG_W-1:0]  n_ang;
    logic              at_last;

    // next angle step: quotient plus carried remainder
    always_comb begin
        rem_sum = {1'b0, r_rem} + {1'b0, i_rem};
        carry   = (rem_sum >= {1'b0, i_sides});
        n_rem   = carry ? SIDE_W'(rem_sum - {1'b0, i_sides}) : SIDE_W'(rem_sum);
        n_ang   = r_ang + i_quot + ANG_W'(carry);
        at_last = (r_j == i_sides);
    end

    // side counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (i_en && r_busy && at_last) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_j      <= '0;
            r_ang    <= '0;
            r_rem    <= '0;
            r_center <= i_center;
        end else if (i_en && r_busy && !at_last) begin
            r_j   <= r_j + SIDE_W'(1);
            r_ang <= n_ang;
            r_rem <= n_rem;
        end
    end

    // one angle per cycle while enabled, a full turn wraps to step zero
    assign o_busy      = r_busy;
    assign o_ctl.valid = r_busy;
    assign o_ctl.first = (r_j == '0);
    assign o_ctl.last  = at_last;
    assign o_k         = (r_ang == ANG_W'(ANGLE_STEPS)) ? '0 : r_ang[K_W-1:0];
    assign o_center    = r_center;

endmodule

@@ hdl/ctg_trig.sv @@
module ctg_trig
    import ctg_pkg::*;
#(
    parameter int ANGLE_STEPS = DEF_ANGLE_STEPS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  t_ctl                             i_ctl,
    input  logic [$clog2(ANGLE_STEPS)-1:0]   i_k,
    input  t_in_item                         i_center,
    output t_ctl                             o_ctl,
    output logic signed [TRIG_W-1:0]         o_sin,
    output logic signed [TRIG_W-1:0]         o_cos,
    output t_in_item                         o_center
);

    localparam int  K_W       = $clog2(ANGLE_STEPS);
    localparam int  NQ        = ANGLE_STEPS / 4;
    localparam int  ROM_DEPTH = NQ + 1;
    localparam int  A_W       = $clog2(ROM_DEPTH);
    localparam real HALF_STEP = 1.5707963267948966 / NQ;

    typedef logic [TRIG_MAG_W-1:0] t_rom [ROM_DEPTH];

    // quarter wave of round(32767*sin), thirty degrees lands exactly on one half
    function automatic t_rom build_rom();
        t_rom rom;
        real  v;
        for (int i = 0; i < ROM_DEPTH; i++) begin
            if (3 * i == NQ) begin
                rom[i] = TRIG_MAG_W'(16384);
            end else begin
                v      = 32767.0 * $sin(HALF_STEP * i) + 0.5;
                rom[i] = TRIG_MAG_W'($rtoi(v));
            end
        end
        return rom;
    endfunction

    localparam t_rom SIN_ROM = build_rom();

    // fold a full-turn step into quarter-wave address and sign
    function automatic logic [A_W:0] fold(input logic [K_W-1:0] k);
        logic [K_W-1:0] r;
        logic           odd;
        logic           neg;
        logic [A_W-1:0] a;
        if (k >= K_W'(3 * NQ)) begin
            r   = k - K_W'(3 * NQ);
            odd = 1'b1;
            neg = 1'b1;
        end else if (k >= K_W'(2 * NQ)) begin
            r   = k - K_W'(2 * NQ);
            odd = 1'b0;
            neg = 1'b1;
        end else if (k >= K_W'(NQ)) begin
            r   = k - K_W'(NQ);
            odd = 1'b1;
            neg = 1'b0;
        end else begin
            r   = k;
            odd = 1'b0;
            neg = 1'b0;
        end
        a = odd ? A_W'(K_W'(NQ) - r) : A_W'(r);
        return {neg, a};
    endfunction

    logic [K_W:0]   kc_sum;
    logic [K_W-1:0] kc;
    logic [A_W:0]   sin_fold;
    logic [A_W:0]   cos_fold;

    // cosine is the sine a quarter turn ahead
    always_comb begin
        kc_sum   = {1'b0, i_k} + (K_W+1)'(NQ);
        kc       = (kc_sum >= (K_W+1)'(ANGLE_STEPS)) ?
                   K_W'(kc_sum - (K_W+1)'(ANGLE_STEPS)) : K_W'(kc_sum);
        sin_fold = fold(i_k);
        cos_fold = fold(kc);
    end

    // stage one: table read
    t_ctl                  r_ctl1;
    t_in_item              r_center1;
    logic [TRIG_MAG_W-1:0] r_sin_mag;
    logic [TRIG_MAG_W-1:0] r_cos_mag;
    logic                  r_sin_neg;
    logic                  r_cos_neg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
        end else if (i_en) begin
            r_ctl1 <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_center1 <= i_center;
            r_sin_mag <= SIN_ROM[sin_fold[A_W-1:0]];
            r_cos_mag <= SIN_ROM[cos_fold[A_W-1:0]];
            r_sin_neg <= sin_fold[A_W];
            r_cos_neg <= cos_fold[A_W];
        end
    end

    // stage two: apply quadrant sign
    logic signed [TRIG_W-1:0] sin_s;
    logic signed [TRIG_W-1:0] cos_s;
    logic signed [TRIG_W-1:0] n_sin;
    logic signed [TRIG_W-1:0] n_cos;

    always_comb begin
        sin_s = $signed({1'b0, r_sin_mag});
        cos_s = $signed({1'b0, r_cos_mag});
        n_sin = r_sin_neg ? -sin_s : sin_s;
        n_cos = r_cos_neg ? -cos_s : cos_s;
    end

    t_ctl                     r_ctl2;
    t_in_item                 r_center2;
    logic signed [TRIG_W-1:0] r_sin;
    logic signed [TRIG_W-1:0] r_cos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl2 <= '0;
        end else if (i_en) begin
            r_ctl2 <= r_ctl1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_center2 <= r_center1;
            r_sin     <= n_sin;
            r_cos     <= n_cos;
        end
    end

    assign o_ctl    = r_ctl2;
    assign o_sin    = r_sin;
    assign o_cos    = r_cos;
    assign o_center = r_center2;

endmodule

@@ hdl/ctg_vtx.sv @@
module ctg_vtx
    import ctg_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  t_ctl                     i_ctl,
    input  t_in_item                 i_center,
    input  logic signed [TRIG_W-1:0] i_sin,
    input  logic signed [TRIG_W-1:0] i_cos,
    input  logic [RADIUS_W-1:0]      i_radius,
    output t_ctl                     o_ctl,
    output t_vertex                  o_vtx,
    output t_in_item                 o_center
);

    localparam int PROD_W = RADIUS_W + 1 + TRIG_W;

    logic signed [RADIUS_W:0] rad_s;

    assign rad_s = $signed({1'b0, i_radius});

    // stage one: radius times sine and cosine
    t_ctl                     r_ctl1;
    t_in_item                 r_center1;
    logic signed [PROD_W-1:0] r_px;
    logic signed [PROD_W-1:0] r_py;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
        end else if (i_en) begin
            r_ctl1 <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_center1 <= i_center;
            r_px      <= rad_s * i_sin;
            r_py      <= rad_s * i_cos;
        end
    end

    // stage two: floor shift by 15 and wrapping add to the center
    logic signed [PROD_W-1:0] off_x;
    logic signed [PROD_W-1:0] off_y;
    t_vertex                  n_vtx;

    always_comb begin
        off_x   = r_px >>> (TRIG_W - 1);
        off_y   = r_py >>> (TRIG_W - 1);
        n_vtx.x = r_center1.center_x + $signed(off_x[COORD_W-1:0]);
        n_vtx.y = r_center1.center_y + $signed(off_y[COORD_W-1:0]);
    end

    t_ctl     r_ctl2;
    t_in_item r_center2;
    t_vertex  r_vtx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl2 <= '0;
        end else if (i_en) begin
            r_ctl2 <= r_ctl1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_center2 <= r_center1;
            r_vtx     <= n_vtx;
        end
    end

    assign o_ctl    = r_ctl2;
    assign o_vtx    = r_vtx;
    assign o_center = r_center2;

endmodule

@@ hdl/circle_tessellation_generator.sv @@
// a center runs through the side sequencer, trig read and sign, vertex multiply and add
//   and the output register; results then come one per cycle unless the output stalls
// S = side count clamped to 1..MAX_SIDES; the side sequencer issues the S+1 rim angles
//   of a circle, one per cycle unless stalled, and takes no new center until all are out
// after reset or a side_count write, centers wait for the bit-serial divider to finish
// reset: synchronous active low, registers return to side_count 16, radius 1.0, fan mode
module circle_tessellation_generator
    import ctg_pkg::*;
#(
    parameter int MAX_SIDES   = DEF_MAX_SIDES,
    parameter int ANGLE_STEPS = DEF_ANGLE_STEPS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  t_in_item               i_in_data,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output t_out_item              o_out_data,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int SIDE_W = $clog2(MAX_SIDES + 1);
    localparam int ANG_W  = $clog2(ANGLE_STEPS + 1);
    localparam int K_W    = $clog2(ANGLE_STEPS);

    // configuration registers
    logic [SIDE_COUNT_W-1:0] r_side_count;
    logic [RADIUS_W-1:0]     r_radius;
    t_mode                   r_mode;
    logic                    r_div_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side_count <= SIDE_COUNT_RESET;
            r_radius     <= RADIUS_RESET;
            r_mode       <= MODE_FAN;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SIDE_COUNT: r_side_count <= i_cfg_data[SIDE_COUNT_W-1:0];
                CFG_RADIUS:     r_radius     <= i_cfg_data[RADIUS_W-1:0];
                CFG_MODE:       r_mode       <= t_mode'(i_cfg_data[0]);
                default:        ;
            endcase
        end
    end

    // effective side count
    logic [SIDE_W-1:0] eff_sides;

    always_comb begin
        if (r_side_count == '0) begin
            eff_sides = SIDE_W'(1);
        end else if (r_side_count > SIDE_COUNT_W'(MAX_SIDES)) begin
            eff_sides = SIDE_W'(MAX_SIDES);
        end else begin
            eff_sides = SIDE_W'(r_side_count);
        end
    end

    // angle step quotient, rerun after reset and on each side count write
    t_div_status       div_status;
    logic [ANG_W-1:0]  div_quot;
    logic [SIDE_W-1:0] div_rem;
    logic              div_start;

    assign div_start = r_div_req && !div_status.busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_req <= 1'b1;
        end else if (i_cfg_we && (i_cfg_index == CFG_SIDE_COUNT)) begin
            r_div_req <= 1'b1;
        end else if (div_start) begin
            r_div_req <= 1'b0;
        end
    end

    ctg_div #(
        .MAX_SIDES   (MAX_SIDES),
        .ANGLE_STEPS (ANGLE_STEPS)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_divisor (eff_sides),
        .o_status  (div_status),
        .o_quot    (div_quot),
        .o_rem     (div_rem)
    );

    // pipeline advance: output register empty or being taken
    logic pipe_en;
    logic seq_busy;
    logic in_accept;

    assign o_in_stall = seq_busy || div_status.busy || r_div_req;
    assign in_accept  = i_in_valid && !o_in_stall;

    // side sequencer
    t_ctl           seq_ctl;
    logic [K_W-1:0] seq_k;
    t_in_item       seq_center;

    ctg_seq #(
        .MAX_SIDES   (MAX_SIDES),
        .ANGLE_STEPS (ANGLE_STEPS)
    ) u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (pipe_en),
        .i_start  (in_accept),
        .i_center (i_in_data),
        .i_sides  (eff_sides),
        .i_quot   (div_quot),
        .i_rem    (div_rem),
        .o_busy   (seq_busy),
        .o_ctl    (seq_ctl),
        .o_k      (seq_k),
        .o_center (seq_center)
    );

    // sine and cosine lookup
    t_ctl                     trig_ctl;
    logic signed [TRIG_W-1:0] trig_sin;
    logic signed [TRIG_W-1:0] trig_cos;
    t_in_item                 trig_center;

    ctg_trig #(
        .ANGLE_STEPS (ANGLE_STEPS)
    ) u_trig (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (pipe_en),
        .i_ctl    (seq_ctl),
        .i_k      (seq_k),
        .i_center (seq_center),
        .o_ctl    (trig_ctl),
        .o_sin    (trig_sin),
        .o_cos    (trig_cos),
        .o_center (trig_center)
    );

    // rim vertex arithmetic
    t_ctl     vtx_ctl;
    t_vertex  vtx;
    t_in_item vtx_center;

    ctg_vtx u_vtx (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (pipe_en),
        .i_ctl    (trig_ctl),
        .i_center (trig_center),
        .i_sin    (trig_sin),
        .i_cos    (trig_cos),
        .i_radius (r_radius),
        .o_ctl    (vtx_ctl),
        .o_vtx    (vtx),
        .o_center (vtx_center)
    );

    // output register pairs each vertex with the one before it
    logic      r_out_valid;
    t_out_item r_out;
    t_vertex   r_prev;

    assign pipe_en = !(r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (pipe_en) begin
            r_out_valid <= vtx_ctl.valid && !vtx_ctl.first;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en && vtx_ctl.valid) begin
            r_prev <= vtx;
            if (!vtx_ctl.first) begin
                r_out.hub_x   <= (r_mode == MODE_LINE) ? '0 : vtx_center.center_x;
                r_out.hub_y   <= (r_mode == MODE_LINE) ? '0 : vtx_center.center_y;
                r_out.lead_x  <= vtx.x;
                r_out.lead_y  <= vtx.y;
                r_out.trail_x <= r_prev.x;
                r_out.trail_y <= r_prev.y;
                r_out.last    <= vtx_ctl.last;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // an accepted center keeps the input stalled while its sides go out
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> o_in_stall)
        else $error("input not stalled after a center transaction");

    // settled divider holds quotient and remainder of the full turn
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!div_status.busy && !r_div_req) |->
        ((32'(div_quot) * 32'(eff_sides) + 32'(div_rem)) == 32'(ANGLE_STEPS)) &&
        (div_rem < eff_sides))
        else $error("angle step divider result wrong");

    // the final angle of a circle closes the turn at step zero
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (seq_ctl.valid && seq_ctl.last) |-> (seq_k == '0))
        else $error("final angle does not close the circle");

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 100ps

module tb;
    import ctg_pkg::*;

    localparam int ANGLE_STEPS = DEF_ANGLE_STEPS;
    localparam int MAX_SIDES   = DEF_MAX_SIDES;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int REPORT_MAX  = 10;
    localparam int SETTLE      = 8;

    // register index past the end of the list, writes to it are dropped
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

    localparam longint unsigned Q62_ONE     = 64'h4000_0000_0000_0000;
    localparam longint unsigned HALF_PI_Q62 = 64'h6487_ED51_10B4_611A;

    logic                   clk;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   in_stall;
    t_in_item               in_data   = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    t_out_item              out_data;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_SIDE_COUNT;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // shadow copy of the register file
    logic [SIDE_COUNT_W-1:0] cur_sides  = SIDE_COUNT_RESET;
    logic [RADIUS_W-1:0]     cur_radius = RADIUS_RESET;
    t_mode                   cur_mode   = MODE_FAN;

    // q1.15 trig tables
    int sine_q15   [ANGLE_STEPS];
    int cosine_q15 [ANGLE_STEPS];

    t_out_item pending_sides [$];

    int send_idle_pct  = 0;
    int stall_pct      = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;

    circle_tessellation_generator dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // clock
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run-away guard
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // receiver back-pressure
    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // (a*b) >> 62 on the full 128-bit product
    function automatic longint unsigned mul_hi62(longint unsigned a, longint unsigned b);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        return prod[125:62];
    endfunction

    // round(32767*sin(2*pi*p/(4*ANGLE_STEPS))), half away from zero
    function automatic int quarter_sine(longint unsigned p);
        longint unsigned n, m, quad, rem, r, x, x2, acc, s, v, d;
        int k;
        n = ANGLE_STEPS;
        // exact half values at 30 degree multiples
        if ((3 * p) % n == 0) begin
            m = ((3 * p) / n) % 12;
            if (m == 1 || m == 5) return 16384;
            if (m == 7 || m == 11) return -16384;
        end
        quad = (p / n) & 64'd3;
        rem  = p % n;
        r    = quad[0] ? (n - rem) : rem;
        x    = (HALF_PI_Q62 / n) * r;
        x2   = mul_hi62(x, x);
        acc  = Q62_ONE;
        // taylor series in horner form
        for (k = 10; k >= 1; k--) begin
            d   = longint'(2 * k) * longint'(2 * k + 1);
            acc = Q62_ONE - mul_hi62(x2, acc) / d;
        end
        s = mul_hi62(x, acc);
        v = ((s >> 22) * 64'd32767 + (64'd1 << 39)) >> 40;
        return (quad >= 2) ? -int'(v) : int'(v);
    endfunction

    function automatic void build_trig_tables();
        for (int k = 0; k < ANGLE_STEPS; k++) begin
            sine_q15[k]   = quarter_sine(4 * k);
            cosine_q15[k] = quarter_sine(4 * k + ANGLE_STEPS);
        end
    endfunction

    function automatic int angle_of(int j, int sides);
        return (j * ANGLE_STEPS / sides) % ANGLE_STEPS;
    endfunction

    // center + floor(r*s / 2^15), wrapping at 32 bits
    function automatic logic [COORD_W-1:0] rim_point(logic [COORD_W-1:0] c,
                                                     logic [RADIUS_W-1:0] r, int s);
        longint prod, off;
        prod = $signed({32'd0, r}) * longint'(s);
        off  = prod >>> 15;
        return c + off[COORD_W-1:0];
    endfunction

    // expected sides of one circle under the current registers
    function automatic void predict_circle(t_in_item c);
        int        sides, la, ta;
        t_out_item r;
        sides = int'(cur_sides);
        if (sides == 0) sides = 1;
        if (sides > MAX_SIDES) sides = MAX_SIDES;
        for (int j = 0; j < sides; j++) begin
            la        = angle_of(j + 1, sides);
            ta        = angle_of(j, sides);
            r.hub_x   = (cur_mode == MODE_LINE) ? '0 : c.center_x;
            r.hub_y   = (cur_mode == MODE_LINE) ? '0 : c.center_y;
            r.lead_x  = rim_point(c.center_x, cur_radius, sine_q15[la]);
            r.lead_y  = rim_point(c.center_y, cur_radius, cosine_q15[la]);
            r.trail_x = rim_point(c.center_x, cur_radius, sine_q15[ta]);
            r.trail_y = rim_point(c.center_y, cur_radius, cosine_q15[ta]);
            r.last    = (j + 1 == sides);
            pending_sides.insert(pending_sides.size(), r);
        end
    endfunction

    // result checker
    always @(posedge clk) begin : check_results
        t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_sides.size() == 0) begin
                if (mismatch_count < REPORT_MAX)
                    $display("unexpected side: got %h", out_data);
                mismatch_count++;
            end else begin
                want = pending_sides.pop_front();
                if (out_data.hub_x !== want.hub_x || out_data.hub_y !== want.hub_y ||
                    out_data.lead_x !== want.lead_x || out_data.lead_y !== want.lead_y ||
                    out_data.trail_x !== want.trail_x ||
                    out_data.trail_y !== want.trail_y || out_data.last !== want.last) begin
                    if (mismatch_count < REPORT_MAX) begin
                        $display("side mismatch at cycle %0d", cycle_count);
                        $display("  exp hub %h %h lead %h %h trail %h %h last %b",
                                 want.hub_x, want.hub_y, want.lead_x, want.lead_y,
                                 want.trail_x, want.trail_y, want.last);
                        $display("  got hub %h %h lead %h %h trail %h %h last %b",
                                 out_data.hub_x, out_data.hub_y, out_data.lead_x,
                                 out_data.lead_y, out_data.trail_x, out_data.trail_y,
                                 out_data.last);
                    end
                    mismatch_count++;
                end
            end
        end
    end

    // one register write, only issued while idle
    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_SIDE_COUNT: cur_sides  = value[SIDE_COUNT_W-1:0];
            CFG_RADIUS:     cur_radius = value;
            CFG_MODE:       cur_mode   = t_mode'(value[0]);
            default: ;
        endcase
        @(posedge clk);
    endtask

    // one center transaction, with random idle gaps in front
    task automatic send_center(logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy);
        t_in_item item;
        item.center_x = cx;
        item.center_y = cy;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (in_stall);
        predict_circle(item);
    endtask

    // wait until every predicted side has come out
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_sides.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_idle(int send_pct, int recv_pct);
        send_idle_pct = send_pct;
        stall_pct     = recv_pct;
    endtask

    function automatic logic [COORD_W-1:0] random_coord();
        if ($urandom_range(99) < 20)
            return $urandom_range(32'h0010_0000) - 32'h0008_0000;
        return $urandom;
    endfunction

    // reset registers: 16 sides, unit radius, fan
    task automatic test_defaults();
        set_idle(0, 0);
        send_center(32'h0000_0000, 32'h0000_0000);
        send_center(32'h7FFF_FFFF, 32'h8000_0000);
        send_center(32'h8000_0000, 32'h7FFF_FFFF);
        send_center($urandom, $urandom);
        drain();
    endtask

    // zero, saturation and masking of the side count
    task automatic test_side_counts();
        logic [CFG_DATA_W-1:0] counts [8];
        counts = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd64, 32'd65, 32'hFFFF_FF7F, 32'hABCD_E005};
        set_idle(11, 11);
        foreach (counts[i]) begin
            write_reg(CFG_SIDE_COUNT, counts[i]);
            send_center($urandom, $urandom);
            drain();
        end
    endtask

    // radius extremes and coordinate wrap
    task automatic test_radius_extremes();
        set_idle(11, 11);
        write_reg(CFG_SIDE_COUNT, 32'd4);
        write_reg(CFG_RADIUS, 32'd0);
        send_center($urandom, $urandom);
        drain();
        write_reg(CFG_RADIUS, 32'hFFFF_FFFF);
        send_center(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_center(32'h8000_0000, 32'h8000_0000);
        drain();
        write_reg(CFG_RADIUS, 32'd1);
        send_center($urandom, $urandom);
        drain();
    endtask

    // outline segments, a write to an index past the list, and back to fan mode
    task automatic test_line_mode();
        set_idle(0, 0);
        write_reg(CFG_MODE, 32'hFFFF_FFFF);
        write_reg(CFG_SIDE_COUNT, 32'd6);
        write_reg(CFG_RADIUS, 32'h0003_0000);
        send_center($urandom, $urandom);
        send_center(32'h0000_0000, 32'h0000_0000);
        drain();
        write_reg(CFG_UNUSED, $urandom);
        send_center($urandom, $urandom);
        drain();
        write_reg(CFG_MODE, 32'hFFFF_FFFE);
        send_center($urandom, $urandom);
        drain();
    endtask

    task automatic randomize_config();
        int                      pick;
        logic [SIDE_COUNT_W-1:0] sc;
        logic [CFG_DATA_W-1:0]   value;
        pick = $urandom_range(99);
        if (pick < 70)      sc = SIDE_COUNT_W'($urandom_range(1, 8));
        else if (pick < 85) sc = SIDE_COUNT_W'($urandom_range(9, MAX_SIDES));
        else                sc = SIDE_COUNT_W'($urandom_range(0, 127));
        value = {25'd0, sc};
        if ($urandom_range(3) == 0)
            value[CFG_DATA_W-1:SIDE_COUNT_W] = (CFG_DATA_W-SIDE_COUNT_W)'($urandom);
        write_reg(CFG_SIDE_COUNT, value);
        case ($urandom_range(3))
            0: value = $urandom;
            1: value = $urandom_range(32'h0004_0000);
            2: value = $urandom_range(1) ? 32'hFFFF_FFFF : 32'd0;
            default: value = $urandom_range(32'h0010_0000, 32'h0001_0000);
        endcase
        write_reg(CFG_RADIUS, value);
        write_reg(CFG_MODE, $urandom);
        if ($urandom_range(3) == 0) write_reg(CFG_UNUSED, $urandom);
    endtask

    // random circles over the idling phases
    task automatic test_random();
        int send_pcts [4];
        int recv_pcts [4];
        send_pcts = '{0, 80, 0, 11};
        recv_pcts = '{0, 0, 80, 11};
        for (int ph = 0; ph < 4; ph++) begin
            set_idle(send_pcts[ph], recv_pcts[ph]);
            repeat (4) begin
                randomize_config();
                repeat (6) send_center(random_coord(), random_coord());
                drain();
            end
        end
    endtask

    // main sequence
    initial begin
        build_trig_tables();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_defaults();
        test_side_counts();
        test_radius_extremes();
        test_line_mode();
        test_random();
        drain();
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
